// ===== design/srt_pkg.sv =====
// Shared types, constants and helpers of the sorted record table.
// No dependencies; used by the interfaces, the match unit and the core.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 16;
  localparam int SCORE_W  = 16;
  localparam int START_W  = 5;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;
  localparam int FILL_W   = 6;
  localparam int ENTRY_W  = KEY_W + SCORE_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd5;

  // Verdict of the compare unit on one entry
  typedef struct packed {
    logic stop;   // scan ends at this entry
    logic exact;  // entry id equals the request id
  } match_t;

  // Fit a table index or count into the result fields
  function automatic logic [POS_W-1:0] pos_field(input logic [CNT_W-1:0] v);
    logic [CNT_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, v};
    return t[POS_W-1:0];
  endfunction

  function automatic logic [FILL_W-1:0] fill_field(input logic [CNT_W-1:0] v);
    logic [CNT_W+FILL_W-1:0] t;
    t = {{FILL_W{1'b0}}, v};
    return t[FILL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/srt_req_if.sv =====
// Request channel of the sorted record table: valid/ready plus request fields.
// Depends on srt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srt_req_if;
  logic                         valid;
  logic                         ready;
  logic [srt_pkg::REQ_W-1:0]    req_type;
  logic [srt_pkg::KEY_W-1:0]    key_id;
  logic [srt_pkg::SCORE_W-1:0]  rec_score;
  logic [srt_pkg::START_W-1:0]  start_index;
  logic                         match_score;

  modport source (output valid, req_type, key_id, rec_score, start_index, match_score,
                  input ready);
  modport sink (input valid, req_type, key_id, rec_score, start_index, match_score,
                output ready);
endinterface

`default_nettype wire

// ===== design/srt_rsp_if.sv =====
// Result channel of the sorted record table: valid/ready plus result fields.
// Depends on srt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [srt_pkg::STATUS_W-1:0]  status;
  logic [srt_pkg::POS_W-1:0]     position;
  logic [srt_pkg::KEY_W-1:0]     found_id;
  logic [srt_pkg::SCORE_W-1:0]   found_score;
  logic [srt_pkg::FILL_W-1:0]    fill_count;

  modport source (output valid, status, position, found_id, found_score, fill_count,
                  input ready);
  modport sink (input valid, status, position, found_id, found_score, fill_count,
                output ready);
endinterface

`default_nettype wire

// ===== design/sorted_record_table_core.sv =====
// Sorted record table core: a table of (id, score) records kept in ascending
// id order in an internal RAM, with a fill count.
// Depends on srt_pkg, srt_req_if, srt_rsp_if, srt_ram and srt_match.
//
// Usage:
//   in_ch  : request transfer (insert sorted, delete by id, search by id or
//            score from a start index). Ready is high only while the core is
//            idle; one request is handled at a time.
//   out_ch : exactly one result transfer per request: status, position,
//            matched record and fill count after the request.
// Operation: the compare unit judges one entry per cycle from a pipelined
//   RAM read; the shift engine moves one entry per cycle. Rejects (zero id,
//   full, empty, unused type, start past fill count) skip the scan. Ready
//   returns as the result appears.
// Reset: synchronous, active low; clears the state, the fill count and the valid flags.
//   Table contents are not cleared; only occupied entries are ever judged or moved.
// Stall: a result waits in the output register while out_ch.ready is low; the
//   core takes one more request meanwhile and holds its result, with ready low,
//   until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module sorted_record_table_core (
  input  wire logic clk,
  input  wire logic rst_n,
  srt_req_if.sink   in_ch,
  srt_rsp_if.source out_ch
);
  import srt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_PLACE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Latched request
  logic [REQ_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic               by_score_r, by_score_nxt;

  // Table control
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0] sh_r, sh_nxt;
  logic             up_r, up_nxt;
  logic [CNT_W-1:0] wr_addr_r, wr_addr_nxt;
  logic             wr_vld_r, wr_vld_nxt;

  // Result being built
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [CNT_W-1:0]    res_pos_r, res_pos_nxt;
  logic [KEY_W-1:0]    res_id_r, res_id_nxt;
  logic [SCORE_W-1:0]  res_score_r, res_score_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [KEY_W-1:0]    out_id_r, out_id_nxt;
  logic [SCORE_W-1:0]  out_score_r, out_score_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;

  // RAM and compare unit
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  match_t             verdict;

  srt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srt_match u_match (
    .op       (op_r),
    .key      (key_r),
    .score    (score_r),
    .by_score (by_score_r),
    .entry    (ram_rdata),
    .verdict  (verdict)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.found_id    = out_id_r;
  assign out_ch.found_score = out_score_r;
  assign out_ch.fill_count  = out_fill_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    score_nxt      = score_r;
    start_nxt      = start_r;
    by_score_nxt   = by_score_r;
    occ_nxt        = occ_r;
    ptr_nxt        = ptr_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    sh_nxt         = sh_r;
    up_nxt         = up_r;
    wr_addr_nxt    = wr_addr_r;
    wr_vld_nxt     = 1'b0;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_id_nxt     = res_id_r;
    res_score_nxt  = res_score_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_id_nxt     = out_id_r;
    out_score_nxt  = out_score_r;
    out_fill_nxt   = out_fill_r;
    ram_we         = 1'b0;
    ram_waddr      = IDX_W'(wr_addr_r);
    ram_wdata      = ram_rdata;
    ram_raddr      = IDX_W'(ptr_r);

    case (state_r)
      // Latch a request on transfer
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.req_type;
          key_nxt      = in_ch.key_id;
          score_nxt    = in_ch.rec_score;
          start_nxt    = in_ch.start_index;
          by_score_nxt = in_ch.match_score;
          state_nxt    = S_START;
        end
      end

      // Reject early or set up the scan
      S_START: begin
        res_status_nxt = STAT_OK;
        res_pos_nxt    = '0;
        res_id_nxt     = '0;
        res_score_nxt  = '0;
        ptr_nxt        = '0;
        state_nxt      = S_SCAN;
        case (op_r)
          REQ_INSERT: begin
            if (key_r == '0) begin
              res_status_nxt = STAT_INVALID;
              state_nxt      = S_DONE;
            end else if (occ_r == CNT_W'(TABLE_DEPTH)) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_DONE;
            end
          end
          REQ_DELETE: begin
            if (occ_r == '0) begin
              res_status_nxt = STAT_EMPTY;
              state_nxt      = S_DONE;
            end
          end
          REQ_SEARCH: begin
            if (occ_r == '0) begin
              res_status_nxt = STAT_EMPTY;
              state_nxt      = S_DONE;
            end else if ({{CNT_W{1'b0}}, start_r} >= {{START_W{1'b0}}, occ_r}) begin
              res_status_nxt = STAT_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              ptr_nxt = CNT_W'({{CNT_W{1'b0}}, start_r});
            end
          end
          default: begin
            res_status_nxt = STAT_INVALID;
            state_nxt      = S_DONE;
          end
        endcase
      end

      // Issue one read per cycle, judge the entry read the cycle before
      S_SCAN: begin
        if (cmp_vld_r && verdict.stop) begin
          res_pos_nxt = cmp_idx_r;
          case (op_r)
            REQ_INSERT: begin
              if (verdict.exact) begin
                res_status_nxt = STAT_DUP;
                state_nxt      = S_DONE;
              end else begin
                sh_nxt    = occ_r;
                up_nxt    = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            REQ_DELETE: begin
              sh_nxt    = cmp_idx_r + CNT_W'(1);
              up_nxt    = 1'b0;
              state_nxt = S_SHIFT;
            end
            default: begin
              res_id_nxt    = ram_rdata[ENTRY_W-1 -: KEY_W];
              res_score_nxt = ram_rdata[SCORE_W-1:0];
              state_nxt     = S_DONE;
            end
          endcase
        end else if (ptr_r < occ_r) begin
          ram_raddr   = IDX_W'(ptr_r);
          cmp_idx_nxt = ptr_r;
          cmp_vld_nxt = 1'b1;
          ptr_nxt     = ptr_r + CNT_W'(1);
        end else if (!cmp_vld_r) begin
          if (op_r == REQ_INSERT) begin
            res_pos_nxt = occ_r;
            sh_nxt      = occ_r;
            up_nxt      = 1'b1;
            state_nxt   = S_SHIFT;
          end else begin
            res_status_nxt = STAT_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end
      end

      // Move entries one slot: read one, write the one read before
      S_SHIFT: begin
        ram_we = wr_vld_r;
        if (up_r) begin
          if (sh_r > res_pos_r) begin
            ram_raddr   = IDX_W'(sh_r - CNT_W'(1));
            wr_addr_nxt = sh_r;
            wr_vld_nxt  = 1'b1;
            sh_nxt      = sh_r - CNT_W'(1);
          end else if (!wr_vld_r) begin
            state_nxt = S_PLACE;
          end
        end else begin
          if (sh_r < occ_r) begin
            ram_raddr   = IDX_W'(sh_r);
            wr_addr_nxt = sh_r - CNT_W'(1);
            wr_vld_nxt  = 1'b1;
            sh_nxt      = sh_r + CNT_W'(1);
          end else if (!wr_vld_r) begin
            occ_nxt   = occ_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end

      // Write the new record into the opened slot
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(res_pos_r);
        ram_wdata = {key_r, score_r};
        occ_nxt   = occ_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = pos_field(res_pos_r);
          out_id_nxt     = res_id_r;
          out_score_nxt  = res_score_r;
          out_fill_nxt   = fill_field(occ_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cmp_vld_r   <= 1'b0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      wr_vld_r    <= wr_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    score_r      <= score_nxt;
    start_r      <= start_nxt;
    by_score_r   <= by_score_nxt;
    ptr_r        <= ptr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    sh_r         <= sh_nxt;
    up_r         <= up_nxt;
    wr_addr_r    <= wr_addr_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_id_r     <= res_id_nxt;
    res_score_r  <= res_score_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_id_r     <= out_id_nxt;
    out_score_r  <= out_score_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  // Fill count never exceeds the table depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  // The compare unit only judges occupied entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmp_vld_r) |-> (cmp_idx_r < occ_r))
    else $error("scan reached an unoccupied entry");

  // Shift writes stay inside the occupied range plus the slot being opened
  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wr_vld_r) |-> (wr_addr_r <= occ_r))
    else $error("shift write beyond the fill count");

  // Placing a record grows the table by exactly one
  a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |=> (occ_r == $past(occ_r) + CNT_W'(1)))
    else $error("insert did not advance the fill count");

endmodule

`default_nettype wire

// ===== design/srt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/srt_match.sv =====
// Shared compare unit: judges one table entry against the current request.
// Depends on srt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srt_match (
  input  wire logic [srt_pkg::REQ_W-1:0]   op,
  input  wire logic [srt_pkg::KEY_W-1:0]   key,
  input  wire logic [srt_pkg::SCORE_W-1:0] score,
  input  wire logic                        by_score,
  input  wire logic [srt_pkg::ENTRY_W-1:0] entry,
  output srt_pkg::match_t                  verdict
);
  import srt_pkg::*;

  logic [KEY_W-1:0]   ent_id;
  logic [SCORE_W-1:0] ent_score;
  logic               id_eq;
  logic               id_gt;
  logic               score_eq;

  assign ent_id    = entry[ENTRY_W-1 -: KEY_W];
  assign ent_score = entry[SCORE_W-1:0];
  assign id_eq     = (ent_id == key);
  assign id_gt     = (ent_id > key);
  assign score_eq  = (ent_score == score);

  // Insert stops at the first id not below the key; delete and search on a hit
  always_comb begin
    verdict.exact = id_eq;
    case (op)
      REQ_INSERT: verdict.stop = id_eq | id_gt;
      REQ_DELETE: verdict.stop = id_eq;
      REQ_SEARCH: verdict.stop = by_score ? score_eq : id_eq;
      default:    verdict.stop = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/tb_sorted_record_table_core.sv =====
// Testbench for sorted_record_table_core: directed and random insert, delete and
// search traffic, each result checked against a behavioral table model.
// Depends on srt_pkg, srt_req_if, srt_rsp_if and the core RTL.
`timescale 1ns / 1ps

module tb_sorted_record_table_core;
  import srt_pkg::*;

  // Request code the core does not implement
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [START_W-1:0] start;
    logic               by_score;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    found_id;
    logic [SCORE_W-1:0]  found_score;
    logic [FILL_W-1:0]   fill;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  srt_req_if req_bus ();
  srt_rsp_if rsp_bus ();

  sorted_record_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (rsp_bus)
  );

  // Table model: id in the upper half, score in the lower half
  logic [ENTRY_W-1:0] rec_tbl [TABLE_DEPTH];
  int unsigned        rec_count = 0;

  outcome_t    pending_outcomes[$];
  int          mismatch_count = 0;
  int          tx_gap_max = 10;
  int          rx_stall_max = 10;
  int          rx_hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the table model and return the outcome it should give
  function automatic outcome_t table_apply(input request_t r);
    outcome_t o;
    int       i;
    int       j;
    logic     hit;
    o = '0;
    o.status = STAT_OK;
    case (r.kind)
      REQ_INSERT: begin
        if (r.key == '0) begin
          o.status = STAT_INVALID;
        end else if (rec_count >= TABLE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          i = 0;
          while (i < rec_count && rec_tbl[i][ENTRY_W-1:SCORE_W] < r.key) i++;
          if (i < rec_count && rec_tbl[i][ENTRY_W-1:SCORE_W] == r.key) begin
            o.status   = STAT_DUP;
            o.position = POS_W'(i);
          end else begin
            for (j = rec_count; j > i; j--) rec_tbl[j] = rec_tbl[j-1];
            rec_tbl[i] = {r.key, r.score};
            rec_count++;
            o.position = POS_W'(i);
          end
        end
      end
      REQ_DELETE: begin
        if (rec_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          o.status = STAT_NOT_FOUND;
          for (i = 0; i < rec_count; i++) begin
            if (o.status == STAT_NOT_FOUND && rec_tbl[i][ENTRY_W-1:SCORE_W] == r.key) begin
              for (j = i; j + 1 < rec_count; j++) rec_tbl[j] = rec_tbl[j+1];
              rec_count--;
              o.status   = STAT_OK;
              o.position = POS_W'(i);
            end
          end
        end
      end
      REQ_SEARCH: begin
        if (rec_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          o.status = STAT_NOT_FOUND;
          for (i = int'(r.start); i < rec_count; i++) begin
            hit = r.by_score ? (rec_tbl[i][SCORE_W-1:0] == r.score)
                             : (rec_tbl[i][ENTRY_W-1:SCORE_W] == r.key);
            if (hit && o.status == STAT_NOT_FOUND) begin
              o.status      = STAT_OK;
              o.position    = POS_W'(i);
              o.found_id    = rec_tbl[i][ENTRY_W-1:SCORE_W];
              o.found_score = rec_tbl[i][SCORE_W-1:0];
            end
          end
        end
      end
      default: o.status = STAT_INVALID;
    endcase
    o.fill = FILL_W'(rec_count);
    return o;
  endfunction

  function automatic request_t mk_request(input logic [REQ_W-1:0] kind,
                                          input logic [KEY_W-1:0] key,
                                          input logic [SCORE_W-1:0] score,
                                          input logic [START_W-1:0] start,
                                          input logic by_score);
    request_t r;
    r.kind     = kind;
    r.key      = key;
    r.score    = score;
    r.start    = start;
    r.by_score = by_score;
    return r;
  endfunction

  // Zero, all-ones, a small id pool (so duplicates and hits are common) or any id
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 11) return KEY_W'($urandom_range(1, 48));
    return KEY_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    if ($urandom_range(0, 1)) return SCORE_W'($urandom_range(0, 7));
    return SCORE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    return rec_tbl[$urandom_range(0, rec_count - 1)][ENTRY_W-1:SCORE_W];
  endfunction

  // Random request; grow biases toward inserts, otherwise toward deletes
  function automatic request_t random_request(input bit grow);
    request_t r;
    int       roll;
    int       idx;
    r = mk_request(REQ_UNUSED, pick_key(), pick_score(), START_W'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      r.kind = REQ_UNUSED;
    end else if (roll < (grow ? 60 : 20)) begin
      r.kind = REQ_INSERT;
    end else if (roll < (grow ? 75 : 72)) begin
      r.kind = REQ_DELETE;
      if (rec_count > 0 && $urandom_range(0, 4) != 0) r.key = stored_key();
    end else begin
      r.kind = REQ_SEARCH;
      if (rec_count > 0 && $urandom_range(0, 3) != 0) begin
        idx     = $urandom_range(0, rec_count - 1);
        r.key   = rec_tbl[idx][ENTRY_W-1:SCORE_W];
        r.score = rec_tbl[idx][SCORE_W-1:0];
        if ($urandom_range(0, 3) != 0) r.start = START_W'($urandom_range(0, idx));
      end
    end
    return r;
  endfunction

  // Offer one request after a random gap and hold it until the transfer
  task automatic send_request(input request_t r);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= r.kind;
    req_bus.key_id      <= r.key;
    req_bus.rec_score   <= r.score;
    req_bus.start_index <= r.start;
    req_bus.match_score <= r.by_score;
    do @(posedge clk); while (!req_bus.ready);
    pending_outcomes.push_back(table_apply(r));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Rejects on an empty table, then a short build, search and tear-down
  task automatic test_directed();
    send_request(mk_request(REQ_DELETE, 16'h0005, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_SEARCH, 16'h0005, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_SEARCH, 16'h0005, 16'h0000, 5'd0, 1'b1));
    send_request(mk_request(REQ_INSERT, 16'h0000, 16'h1111, 5'd0, 1'b0));
    send_request(mk_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1));
    send_request(mk_request(REQ_INSERT, 16'h8000, 16'h1234, 5'd0, 1'b0));
    send_request(mk_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1));
    send_request(mk_request(REQ_INSERT, 16'h0001, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_INSERT, 16'h4000, 16'hABCD, 5'd0, 1'b0));
    send_request(mk_request(REQ_INSERT, 16'h4000, 16'h5555, 5'd0, 1'b0));
    send_request(mk_request(REQ_INSERT, 16'h0000, 16'h5555, 5'd0, 1'b0));
    send_request(mk_request(REQ_SEARCH, 16'hFFFF, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_SEARCH, 16'h0001, 16'h0000, 5'd1, 1'b0));
    send_request(mk_request(REQ_SEARCH, 16'h0000, 16'hFFFF, 5'd0, 1'b1));
    send_request(mk_request(REQ_SEARCH, 16'hFFFF, 16'h0000, 5'd0, 1'b1));
    send_request(mk_request(REQ_SEARCH, 16'hFFFF, 16'hFFFF, 5'd31, 1'b0));
    send_request(mk_request(REQ_SEARCH, 16'hFFFF, 16'hFFFF, 5'd4, 1'b1));
    send_request(mk_request(REQ_SEARCH, 16'h0000, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_UNUSED, 16'h4000, 16'hABCD, 5'd0, 1'b0));
    send_request(mk_request(REQ_DELETE, 16'h4000, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_DELETE, 16'h0001, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_DELETE, 16'h1234, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_DELETE, 16'h0000, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_DELETE, 16'hFFFF, 16'h0000, 5'd0, 1'b0));
    send_request(mk_request(REQ_DELETE, 16'h8000, 16'h0000, 5'd0, 1'b0));
  endtask

  // Fill to capacity, hit the full-table rejects and the last slot, then drain
  task automatic test_full_table();
    logic [KEY_W-1:0] last_key;
    logic [SCORE_W-1:0] last_score;
    while (rec_count < TABLE_DEPTH)
      send_request(mk_request(REQ_INSERT, KEY_W'($urandom_range(1, 65535)), pick_score(),
                              START_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
    last_key   = rec_tbl[TABLE_DEPTH-1][ENTRY_W-1:SCORE_W];
    last_score = rec_tbl[TABLE_DEPTH-1][SCORE_W-1:0];
    send_request(mk_request(REQ_INSERT, KEY_W'($urandom_range(1, 65535)), 16'h0, 5'd0, 1'b0));
    send_request(mk_request(REQ_INSERT, 16'h0000, 16'h0, 5'd0, 1'b0));
    send_request(mk_request(REQ_INSERT, stored_key(), 16'h0, 5'd0, 1'b0));
    send_request(mk_request(REQ_SEARCH, last_key, 16'h0, 5'd31, 1'b0));
    send_request(mk_request(REQ_SEARCH, 16'h0, last_score, 5'd31, 1'b1));
    send_request(mk_request(REQ_SEARCH, 16'h0, last_score, 5'd0, 1'b1));
    while (rec_count > 0)
      send_request(mk_request(REQ_DELETE, stored_key(), pick_score(),
                              START_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
  endtask

  // Alternate growing and shrinking phases so the table swings full and empty
  task automatic test_random_mix(input int count);
    bit grow;
    grow = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) grow = !grow;
      if (rec_count == TABLE_DEPTH) grow = 1'b0;
      if (rec_count == 0) grow = 1'b1;
      send_request(random_request(grow));
    end
  endtask

  // Hold the result side off long enough that the core stalls its input
  task automatic test_result_backpressure();
    rx_hold_cycles = 400;
    for (int n = 0; n < 8; n++) send_request(random_request(1'b1));
    wait_results_drained();
  endtask

  // No gaps on either side
  task automatic test_back_to_back(input int count);
    tx_gap_max   = 0;
    rx_stall_max = 0;
    for (int n = 0; n < count; n++) send_request(random_request(n < count / 2));
    wait_results_drained();
    tx_gap_max   = 10;
    rx_stall_max = 10;
  endtask

  // Result side: random stalls, plus a long hold when one is requested
  initial begin
    int stall;
    rsp_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        @(negedge clk);
        rsp_bus.ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        @(negedge clk);
        rsp_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // Compare each result transfer with the oldest outstanding outcome
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got = {rsp_bus.status, rsp_bus.position, rsp_bus.found_id, rsp_bus.found_score,
             rsp_bus.fill_count};
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("result with nothing outstanding: %h", got));
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.position !== want.position)
          note_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
        if (got.found_id !== want.found_id)
          note_mismatch($sformatf("found_id %h, want %h", got.found_id, want.found_id));
        if (got.found_score !== want.found_score)
          note_mismatch($sformatf("found_score %h, want %h", got.found_score,
                                  want.found_score));
        if (got.fill !== want.fill)
          note_mismatch($sformatf("fill_count %0d, want %0d", got.fill, want.fill));
      end
    end
  end

  // Hard stop in case the core hangs
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_INSERT;
    req_bus.key_id      = '0;
    req_bus.rec_score   = '0;
    req_bus.start_index = '0;
    req_bus.match_score = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_table();
    test_random_mix(600);
    test_result_backpressure();
    test_back_to_back(80);

    // Let the last results land, then allow a worst-case request time more
    wait_results_drained();
    repeat (2 * TABLE_DEPTH + 20) @(posedge clk);
    if (pending_outcomes.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
